@@ rtl/sqvt_pkg.sv @@
package sqvt_pkg;

   // Taylor coefficients of the quarter-wave sine, unsigned Q.30
   localparam logic [30:0] COEF_A = 31'd1686629713;
   localparam logic [30:0] COEF_B = 31'd693598668;
   localparam logic [30:0] COEF_C = 31'd85569306;
   localparam logic [30:0] COEF_D = 31'd5026995;
   localparam logic [30:0] COEF_E = 31'd172272;

   localparam logic [16:0] Q16_ONE = 17'd65536;
   localparam int TRIG_STAGES = 8;
   localparam logic [1:0] LAST_CORNER = 2'd3;

   typedef struct packed {
      logic [11:0]        w;
      logic [11:0]        h;
      logic [28:0]        ox;
      logic [28:0]        oy;
      logic [15:0]        sx;
      logic [15:0]        sy;
      logic signed [31:0] posx;
      logic signed [31:0] posy;
   } sqvt_geom_type;

   typedef struct packed {
      logic signed [17:0] sn;
      logic signed [17:0] cs;
      sqvt_geom_type      geo;
   } sqvt_item_type;

endpackage

@@ rtl/sqvt_trig.sv @@
module sqvt_trig (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [11:0]           req_sprite_width,
   input  logic [11:0]           req_sprite_height,
   input  logic [16:0]           req_pivot_x_frac,
   input  logic [16:0]           req_pivot_y_frac,
   input  logic [15:0]           req_scale_x_q,
   input  logic [15:0]           req_scale_y_q,
   input  logic [15:0]           req_turn_angle,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_y,
   output logic                  tr_valid,
   output sqvt_pkg::sqvt_item_type tr_item,
   input  logic                  tr_take_ok
);
   import sqvt_pkg::*;

   function automatic logic [30:0] q30_mul(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = a * b;
      return p[60:30];
   endfunction

   logic                  adv;
   logic [TRIG_STAGES:1]  v_ff;

   // stage 1
   logic [15:0] b_in;
   logic [14:0] tc_in;
   logic [16:0] px_in, py_in;
   logic [30:0] zs_ff [1:6];
   logic [30:0] zc_ff [1:6];
   logic [1:0]  q_ff [1:7];
   logic        zero_ff [1:7];
   logic [11:0] w1_ff, h1_ff;
   logic [16:0] px1_ff, pyi1_ff;
   logic [15:0] sx1_ff, sy1_ff;
   logic signed [31:0] posx1_ff, posy1_ff;

   // stages 2 to 8
   sqvt_geom_type geo_in;
   sqvt_geom_type geo_ff [2:7];
   logic [30:0] z2s_ff [2:5];
   logic [30:0] z2c_ff [2:5];
   logic [30:0] ps_ff [3:6];
   logic [30:0] pc_ff [3:6];
   logic [30:0] vs7_ff, vc7_ff;
   sqvt_item_type item8_ff, item_in;

   logic [31:0] rs_sum, rc_sum;
   logic [16:0] st, ct;
   logic signed [17:0] st_p, st_n, ct_p, ct_n;

   assign adv       = !v_ff[TRIG_STAGES] || tr_take_ok;
   assign req_stall = !adv;
   assign tr_valid  = v_ff[TRIG_STAGES];
   assign tr_item   = item8_ff;

   assign b_in  = 16'(~req_turn_angle + 16'd1);
   // cosine argument is the complement of the quarter-wave offset
   assign tc_in = 15'(15'd16384 - {1'b0, b_in[13:0]});
   assign px_in = (req_pivot_x_frac > Q16_ONE) ? Q16_ONE : req_pivot_x_frac;
   assign py_in = (req_pivot_y_frac > Q16_ONE) ? Q16_ONE : req_pivot_y_frac;

   always_comb begin
      geo_in.w    = w1_ff;
      geo_in.h    = h1_ff;
      geo_in.ox   = 29'(w1_ff * px1_ff);
      geo_in.oy   = 29'(h1_ff * pyi1_ff);
      geo_in.sx   = sx1_ff;
      geo_in.sy   = sy1_ff;
      geo_in.posx = posx1_ff;
      geo_in.posy = posy1_ff;
   end

   assign rs_sum = {1'b0, vs7_ff} + 32'd8192;
   assign rc_sum = {1'b0, vc7_ff} + 32'd8192;
   assign st = (rs_sum[31:14] > {1'b0, Q16_ONE}) ? Q16_ONE : rs_sum[30:14];
   assign ct = (rc_sum[31:14] > {1'b0, Q16_ONE}) ? Q16_ONE : rc_sum[30:14];
   assign st_p = $signed({1'b0, st});
   assign ct_p = $signed({1'b0, ct});
   assign st_n = -st_p;
   assign ct_n = -ct_p;

   always_comb begin
      item_in.geo = geo_ff[7];
      if (zero_ff[7]) begin
         item_in.sn = 18'sd0;
         item_in.cs = $signed({1'b0, Q16_ONE});
      end else begin
         unique case (q_ff[7])
            2'd0: begin item_in.sn = st_p; item_in.cs = ct_p; end
            2'd1: begin item_in.sn = ct_p; item_in.cs = st_n; end
            2'd2: begin item_in.sn = st_n; item_in.cs = ct_n; end
            default: begin item_in.sn = ct_n; item_in.cs = st_p; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[TRIG_STAGES-1:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zs_ff[1]   <= {1'b0, b_in[13:0], 16'h0};
         zc_ff[1]   <= {tc_in, 16'h0};
         q_ff[1]    <= b_in[15:14];
         zero_ff[1] <= (req_turn_angle == 16'd0);
         w1_ff      <= req_sprite_width;
         h1_ff      <= req_sprite_height;
         px1_ff     <= px_in;
         pyi1_ff    <= Q16_ONE - py_in;
         sx1_ff     <= req_scale_x_q;
         sy1_ff     <= req_scale_y_q;
         posx1_ff   <= req_pos_x;
         posy1_ff   <= req_pos_y;
         for (int i = 2; i <= 6; i++) begin
            zs_ff[i] <= zs_ff[i-1];
            zc_ff[i] <= zc_ff[i-1];
         end
         for (int i = 2; i <= 7; i++) begin
            q_ff[i]    <= q_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
         end
         geo_ff[2] <= geo_in;
         for (int i = 3; i <= 7; i++) begin
            geo_ff[i] <= geo_ff[i-1];
         end
         z2s_ff[2] <= q30_mul(zs_ff[1], zs_ff[1]);
         z2c_ff[2] <= q30_mul(zc_ff[1], zc_ff[1]);
         for (int i = 3; i <= 5; i++) begin
            z2s_ff[i] <= z2s_ff[i-1];
            z2c_ff[i] <= z2c_ff[i-1];
         end
         // Horner steps, one multiply per stage
         ps_ff[3] <= COEF_D - q30_mul(z2s_ff[2], COEF_E);
         pc_ff[3] <= COEF_D - q30_mul(z2c_ff[2], COEF_E);
         ps_ff[4] <= COEF_C - q30_mul(z2s_ff[3], ps_ff[3]);
         pc_ff[4] <= COEF_C - q30_mul(z2c_ff[3], pc_ff[3]);
         ps_ff[5] <= COEF_B - q30_mul(z2s_ff[4], ps_ff[4]);
         pc_ff[5] <= COEF_B - q30_mul(z2c_ff[4], pc_ff[4]);
         ps_ff[6] <= COEF_A - q30_mul(z2s_ff[5], ps_ff[5]);
         pc_ff[6] <= COEF_A - q30_mul(z2c_ff[5], pc_ff[5]);
         vs7_ff   <= q30_mul(zs_ff[6], ps_ff[6]);
         vc7_ff   <= q30_mul(zc_ff[6], pc_ff[6]);
         item8_ff <= item_in;
      end
   end

endmodule

@@ rtl/sqvt_corner.sv @@
module sqvt_corner (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tr_valid,
   input  sqvt_pkg::sqvt_item_type tr_item,
   output logic                    tr_take_ok,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_corner,
   output logic signed [31:0]      rsp_vertex_x,
   output logic signed [31:0]      rsp_vertex_y,
   output logic                    rsp_last_corner
);
   import sqvt_pkg::*;

   function automatic logic [31:0] sat32(input logic signed [34:0] v);
      logic [31:0] r;
      if (v > 35'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -35'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   logic          en;
   logic          ex_valid_ff;
   logic [1:0]    ex_k_ff;
   sqvt_item_type ex_item_ff;

   logic [4:0]         cv_ff;
   logic [1:0]         k_ff [0:4];
   logic signed [31:0] posx_ff [0:4];
   logic signed [31:0] posy_ff [0:4];
   logic [15:0]        sx_ff [0:2];
   logic [15:0]        sy_ff [0:2];
   logic signed [17:0] sn0_ff, cs0_ff;
   logic signed [29:0] cx0_ff, cy0_ff, ox_s, oy_s, cx_in, cy_in;
   logic signed [47:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [48:0] rx_ff, ry_ff;
   logic signed [65:0] mx_ff, my_ff, mx_r, my_r;
   logic signed [33:0] rnx_ff, rny_ff;
   logic signed [34:0] sumx, sumy;

   logic               rsp_valid_ff, rsp_last_ff;
   logic [1:0]         rsp_corner_ff;
   logic [31:0]        rsp_x_ff, rsp_y_ff;

   assign en         = !(rsp_valid_ff && rsp_stall);
   assign tr_take_ok = en && (!ex_valid_ff || ex_k_ff == LAST_CORNER);

   assign ox_s  = $signed({1'b0, ex_item_ff.geo.ox});
   assign oy_s  = $signed({1'b0, ex_item_ff.geo.oy});
   assign cx_in = ex_k_ff[0] ? ox_s - $signed({2'b0, ex_item_ff.geo.w, 16'h0}) : ox_s;
   assign cy_in = ex_k_ff[1] ? oy_s - $signed({2'b0, ex_item_ff.geo.h, 16'h0}) : oy_s;

   // round Q.40 to Q.8: add half, floor by arithmetic shift
   assign mx_r = mx_ff + 66'sd2147483648;
   assign my_r = my_ff + 66'sd2147483648;
   assign sumx = rnx_ff + posx_ff[4];
   assign sumy = rny_ff + posy_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         ex_k_ff      <= 2'd0;
         cv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         if (!ex_valid_ff || ex_k_ff == LAST_CORNER) begin
            ex_valid_ff <= tr_valid;
            ex_k_ff     <= 2'd0;
         end else begin
            ex_k_ff <= ex_k_ff + 2'd1;
         end
         cv_ff        <= {cv_ff[3:0], ex_valid_ff};
         rsp_valid_ff <= cv_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (tr_take_ok && tr_valid) begin
         ex_item_ff <= tr_item;
      end
      if (en) begin
         k_ff[0]    <= ex_k_ff;
         posx_ff[0] <= ex_item_ff.geo.posx;
         posy_ff[0] <= ex_item_ff.geo.posy;
         sx_ff[0]   <= ex_item_ff.geo.sx;
         sy_ff[0]   <= ex_item_ff.geo.sy;
         sn0_ff     <= ex_item_ff.sn;
         cs0_ff     <= ex_item_ff.cs;
         cx0_ff     <= cx_in;
         cy0_ff     <= cy_in;
         for (int i = 1; i <= 4; i++) begin
            k_ff[i]    <= k_ff[i-1];
            posx_ff[i] <= posx_ff[i-1];
            posy_ff[i] <= posy_ff[i-1];
         end
         for (int i = 1; i <= 2; i++) begin
            sx_ff[i] <= sx_ff[i-1];
            sy_ff[i] <= sy_ff[i-1];
         end
         pa_ff  <= cs0_ff * cx0_ff;
         pb_ff  <= sn0_ff * cy0_ff;
         pc_ff  <= sn0_ff * cx0_ff;
         pd_ff  <= cs0_ff * cy0_ff;
         rx_ff  <= pa_ff - pb_ff;
         ry_ff  <= pc_ff + pd_ff;
         mx_ff  <= rx_ff * $signed({1'b0, sx_ff[2]});
         my_ff  <= ry_ff * $signed({1'b0, sy_ff[2]});
         rnx_ff <= mx_r[65:32];
         rny_ff <= my_r[65:32];
         rsp_corner_ff <= k_ff[4];
         rsp_last_ff   <= (k_ff[4] == LAST_CORNER);
         rsp_x_ff      <= sat32(sumx);
         rsp_y_ff      <= sat32(sumy);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_corner      = rsp_corner_ff;
   assign rsp_vertex_x    = rsp_x_ff;
   assign rsp_vertex_y    = rsp_y_ff;
   assign rsp_last_corner = rsp_last_ff;

endmodule

@@ rtl/sprite_quad_vertex_transform_core.sv @@
// Sprite quad corner transform.
// req_ channel: one item per sprite (size, pivot, scale, angle, position).
// rsp_ channel: four items per sprite, corners 0..3 in strip order, with
// rsp_last_corner set on corner 3. Transfers happen when valid is high and
// stall is low.
// Corner 0 shows on rsp_ after the trig and corner pipelines; corners 1..3
// follow in the next cycles when the receiver does not stall. The corner
// counter feeds one corner per cycle into the single result port while
// rsp_stall lets it, taking a new sprite with corner 3. The sine/cosine
// pipeline (8 stages) takes a new request every cycle while it has room.
// Reset (synchronous) empties every pipeline stage; no results are pending.
// When rsp_stall is high with a result shown, the corner pipeline freezes
// and the result holds; the trig pipeline keeps filling until its last
// stage is occupied, then req_stall goes high.
module sprite_quad_vertex_transform_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_sprite_width,
   input  logic [11:0]        req_sprite_height,
   input  logic [16:0]        req_pivot_x_frac,
   input  logic [16:0]        req_pivot_y_frac,
   input  logic [15:0]        req_scale_x_q,
   input  logic [15:0]        req_scale_y_q,
   input  logic [15:0]        req_turn_angle,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_corner,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_y,
   output logic               rsp_last_corner
);
   import sqvt_pkg::*;

   logic          tr_valid;
   logic          tr_take_ok;
   sqvt_item_type tr_item;

   sqvt_trig u_trig (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sprite_width  (req_sprite_width),
      .req_sprite_height (req_sprite_height),
      .req_pivot_x_frac  (req_pivot_x_frac),
      .req_pivot_y_frac  (req_pivot_y_frac),
      .req_scale_x_q     (req_scale_x_q),
      .req_scale_y_q     (req_scale_y_q),
      .req_turn_angle    (req_turn_angle),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .tr_valid          (tr_valid),
      .tr_item           (tr_item),
      .tr_take_ok        (tr_take_ok)
   );

   sqvt_corner u_corner (
      .clock           (clock),
      .reset           (reset),
      .tr_valid        (tr_valid),
      .tr_item         (tr_item),
      .tr_take_ok      (tr_take_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_corner      (rsp_corner),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_last_corner (rsp_last_corner)
   );

endmodule

@@ rtl/sqvt_checker.sv @@
module sqvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_corner,
   input logic [31:0] rsp_vertex_x,
   input logic [31:0] rsp_vertex_y,
   input logic        rsp_last_corner
);
   import sqvt_pkg::*;

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_corner == (rsp_corner == LAST_CORNER)))
      else $error("last flag does not match corner");

   a_corners_adjacent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_corner != 2'd0 |-> $past(rsp_valid))
      else $error("corner of a sprite shown after a gap");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vertex_x)
         && $stable(rsp_vertex_y) && $stable(rsp_corner))
      else $error("stalled result changed");

endmodule

bind sprite_quad_vertex_transform_core sqvt_checker u_sqvt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_corner      (rsp_corner),
   .rsp_vertex_x    (rsp_vertex_x),
   .rsp_vertex_y    (rsp_vertex_y),
   .rsp_last_corner (rsp_last_corner)
);

@@ dv/testbench.sv @@
module testbench;
   import sqvt_pkg::*;

   typedef struct {
      logic [11:0]        w;
      logic [11:0]        h;
      logic [16:0]        px;
      logic [16:0]        py;
      logic [15:0]        sx;
      logic [15:0]        sy;
      logic [15:0]        ang;
      logic signed [31:0] posx;
      logic signed [31:0] posy;
   } sprite_type;

   typedef struct {
      logic [1:0]         corner;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic               last;
   } vertex_type;

   // known = 1: corner 0 result typed in, checked as well as predicted
   typedef struct {
      sprite_type         spr;
      bit                 known;
      logic signed [31:0] vx0;
      logic signed [31:0] vy0;
   } row_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [11:0]        req_sprite_width = 0;
   logic [11:0]        req_sprite_height = 0;
   logic [16:0]        req_pivot_x_frac = 0;
   logic [16:0]        req_pivot_y_frac = 0;
   logic [15:0]        req_scale_x_q = 0;
   logic [15:0]        req_scale_y_q = 0;
   logic [15:0]        req_turn_angle = 0;
   logic signed [31:0] req_pos_x = 0;
   logic signed [31:0] req_pos_y = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [1:0]         rsp_corner;
   logic signed [31:0] rsp_vertex_x;
   logic signed [31:0] rsp_vertex_y;
   logic               rsp_last_corner;

   vertex_type pending_vertices[$];
   int         errors = 0;
   int         rsp_wait = 0;
   bit         hold_start = 0;
   bit         hold_long = 0;
   bit         stim_done = 0;

   sprite_quad_vertex_transform_core DUT (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic longint qsine(int unsigned t);
      longint unsigned z, z2, p, v;
      z = longint'(t & 32'h7FFF) << 16;
      if (z > 64'd1073741824) z = 64'd1073741824;
      z2 = (z * z) >> 30;
      p = COEF_E;
      p = COEF_D - ((z2 * p) >> 30);
      p = COEF_C - ((z2 * p) >> 30);
      p = COEF_B - ((z2 * p) >> 30);
      p = COEF_A - ((z2 * p) >> 30);
      v = (z * p) >> 30;
      v = (v + 8192) >> 14;
      if (v > 65536) v = 65536;
      return longint'(v);
   endfunction

   function automatic longint round_to_q8(longint v);
      longint r;
      r = v + (64'sd1 <<< 31);
      if (r >= 0) return r >>> 32;
      return -(((-r) + ((64'sd1 <<< 32) - 1)) >>> 32);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic predict_corners(sprite_type s);
      longint w, h, px, py, sn, cs, st, ct, ox, oy, cx, cy, rx, ry;
      int unsigned b, t;
      vertex_type v;
      w = s.w;
      h = s.h;
      px = (s.px > 65536) ? 65536 : s.px;
      py = (s.py > 65536) ? 65536 : s.py;
      ox = w * px;
      oy = h * (65536 - py);
      if (s.ang == 0) begin
         sn = 0;
         cs = 65536;
      end else begin
         b = (65536 - s.ang) & 16'hFFFF;
         t = b & 16383;
         st = qsine(t);
         ct = qsine(16384 - t);
         case (b >> 14)
            0: begin sn = st;  cs = ct;  end
            1: begin sn = ct;  cs = -st; end
            2: begin sn = -st; cs = -ct; end
            default: begin sn = -ct; cs = st; end
         endcase
      end
      for (int k = 0; k < 4; k++) begin
         cx = k[0] ? ox - w * 65536 : ox;
         cy = k[1] ? oy - h * 65536 : oy;
         rx = cs * cx - sn * cy;
         ry = sn * cx + cs * cy;
         v.corner = 2'(k);
         v.vx = clamp32(round_to_q8(rx * longint'(s.sx)) + s.posx);
         v.vy = clamp32(round_to_q8(ry * longint'(s.sy)) + s.posy);
         v.last = (k == 3);
         pending_vertices.push_back(v);
      end
   endtask

   task automatic send_sprite(sprite_type s);
      repeat ($urandom_range(0, 3)) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sprite_width <= s.w;
      req_sprite_height <= s.h;
      req_pivot_x_frac <= s.px;
      req_pivot_y_frac <= s.py;
      req_scale_x_q <= s.sx;
      req_scale_y_q <= s.sy;
      req_turn_angle <= s.ang;
      req_pos_x <= s.posx;
      req_pos_y <= s.posy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_corners(s);
   endtask

   function automatic sprite_type rand_sprite();
      sprite_type s;
      s.w = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 64));
      s.h = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 64));
      s.px = ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      s.py = ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      s.sx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      s.sy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      case ($urandom_range(0, 3))
         0: s.ang = 0;
         1: s.ang = 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
         default: s.ang = 16'($urandom);
      endcase
      s.posx = ($urandom_range(0, 3) == 0) ? $signed($urandom) :
               $signed(32'($urandom_range(0, 65535)) - 32'd32768);
      s.posy = ($urandom_range(0, 3) == 0) ? $signed($urandom) :
               $signed(32'($urandom_range(0, 65535)) - 32'd32768);
      return s;
   endfunction

   // receiver: a random wait after each item, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_vertices.size() == 0) begin
               $display("%0t: unexpected corner %0d x=%0d y=%0d", $time, rsp_corner,
                        rsp_vertex_x, rsp_vertex_y);
               errors++;
            end else begin
               vertex_type e;
               e = pending_vertices.pop_front();
               if (rsp_corner !== e.corner || rsp_vertex_x !== e.vx ||
                   rsp_vertex_y !== e.vy || rsp_last_corner !== e.last) begin
                  $display("%0t: expected c=%0d x=%0d y=%0d l=%0b, got c=%0d x=%0d y=%0d l=%0b",
                           $time, e.corner, e.vx, e.vy, e.last, rsp_corner,
                           rsp_vertex_x, rsp_vertex_y, rsp_last_corner);
                  errors++;
               end
            end
            rsp_wait = $urandom_range(0, 3);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_stall <= hold_long || (rsp_wait > 0);
      end
   end

   initial begin
      row_type    rows[$];
      row_type    r;
      vertex_type v;
      // identity sprite: zero size, unit scale, angle zero -> position
      r.known = 1;
      r.spr = '{0, 0, 0, 0, 256, 256, 0, 0, 0};
      r.vx0 = 0; r.vy0 = 0; rows.push_back(r);
      r.spr = '{0, 0, 0, 0, 256, 256, 0, 32'sh7FFFFFFF, 32'sh80000000};
      r.vx0 = 32'sh7FFFFFFF; r.vy0 = 32'sh80000000; rows.push_back(r);
      // zero scale collapses onto the position
      r.spr = '{4095, 4095, 65536, 0, 0, 0, 16'h1234, 1000, -1000};
      r.vx0 = 1000; r.vy0 = -1000; rows.push_back(r);
      // saturation both ways
      r.spr = '{4095, 4095, 0, 0, 65535, 65535, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
      r.vx0 = 32'sh7FFFFFFF; r.vy0 = 32'sh7FFFFFFF; rows.push_back(r);
      r.known = 0;
      r.spr = '{4095, 4095, 65536, 65536, 65535, 65535, 0, 32'sh80000000, 32'sh80000000};
      rows.push_back(r);
      // pivot above one is clamped
      r.spr = '{100, 50, 17'h1FFFF, 17'h1FFFF, 256, 256, 0, 0, 0}; rows.push_back(r);
      r.spr = '{100, 50, 32768, 32768, 256, 256, 0, 0, 0}; rows.push_back(r);
      for (int a = 0; a < 8; a++) begin
         r.spr = '{64, 32, 32768, 16384, 384, 128, 16'(a * 16'h2000), 2560, -2560};
         rows.push_back(r);
      end
      r.spr = '{10, 10, 0, 65536, 256, 256, 16'hFFFF, 0, 0}; rows.push_back(r);
      r.spr = '{10, 10, 0, 65536, 256, 256, 16'h0001, 0, 0}; rows.push_back(r);
      r.spr = '{12'hAAA, 12'h555, 17'h0AAAA, 17'h15555, 16'hAAAA, 16'h5555, 16'hAAAA,
                32'shAAAAAAAA, 32'sh55555555};
      rows.push_back(r);
      r.spr = '{12'h555, 12'hAAA, 17'h15555, 17'h0AAAA, 16'h5555, 16'hAAAA, 16'h5555,
                32'sh55555555, 32'shAAAAAAAA};
      rows.push_back(r);

      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) begin
         send_sprite(rows[i].spr);
         if (rows[i].known) begin
            v = pending_vertices[pending_vertices.size() - 4];
            if (v.vx !== rows[i].vx0 || v.vy !== rows[i].vy0) begin
               $display("%0t: row %0d table x=%0d y=%0d, model x=%0d y=%0d", $time, i,
                        rows[i].vx0, rows[i].vy0, v.vx, v.vy);
               errors++;
            end
         end
      end
      for (int n = 0; n < 230; n++) begin
         if (n == 60) hold_start = 1;
         send_sprite(rand_sprite());
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // long receiver hold-off, counted here so the sender keeps pushing
   initial begin
      wait (hold_start);
      hold_long <= 1;
      repeat (120) @(posedge clock);
      hold_long <= 0;
   end

   initial begin
      wait (stim_done);
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("sprite_quad_vertex_transform_core verification clean");
      else $display("sprite_quad_vertex_transform_core verification failed");
      $finish;
   end

   initial begin
      #400000;
      $display("sprite_quad_vertex_transform_core verification failed");
      $finish;
   end

endmodule
